// ===== rtl/core/ethpc_pkg.sv =====
`default_nettype none

package ethpc_pkg;

	typedef enum logic [1:0] {
		ACT_READ   = 2'd0,
		ACT_WRITE  = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_ENGINE = 2'd3
	} ethpc_action_t;

	// CSR word indexes
	localparam logic [1:0] CSR_0 = 2'd0;
	localparam logic [1:0] CSR_1 = 2'd1;
	localparam logic [1:0] CSR_2 = 2'd2;
	localparam logic [1:0] CSR_3 = 2'd3;

	// port commands held in CSR0 bits 3..0
	localparam logic [3:0] CMD_NONE      = 4'd0;
	localparam logic [3:0] CMD_GET_PCB   = 4'd1;
	localparam logic [3:0] CMD_GET_CMD   = 4'd2;
	localparam logic [3:0] CMD_SELF_TEST = 4'd3;
	localparam logic [3:0] CMD_RUN       = 4'd4;
	localparam logic [3:0] CMD_POLL      = 4'd8;
	localparam logic [3:0] CMD_HALT      = 4'd15;

	// port states held in CSR1 bits 3..0
	localparam logic [3:0] ST_RESET   = 4'd0;
	localparam logic [3:0] ST_READY   = 4'd2;
	localparam logic [3:0] ST_RUNNING = 4'd3;

	// engine requests
	localparam logic [1:0] EREQ_NONE    = 2'd0;
	localparam logic [1:0] EREQ_GET_CMD = 2'd1;
	localparam logic [1:0] EREQ_POLL    = 2'd2;

	// CSR0 bit positions
	localparam int unsigned BIT_ENABLE = 6;
	localparam int unsigned BIT_RESET  = 5;

	// interrupt bits 15..8; bit 11 of CSR0 is DONE, bit 3 of the byte
	localparam logic [15:0] IRQ_DONE = 16'h0800;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  reg_select;
		logic [15:0] write_data;
		logic [15:0] engine_bits;
	} ethpc_item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        irq_request;
		logic [1:0]  engine_request;
		logic [17:0] block_base;
	} ethpc_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ethpc_if.sv =====
`default_nettype none

interface ethpc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [1:0]  reg_select;
	logic [15:0] write_data;
	logic [15:0] engine_bits;

	modport source (output valid, action, reg_select, write_data, engine_bits, input ready);
	modport sink (input valid, action, reg_select, write_data, engine_bits, output ready);
endinterface

interface ethpc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic        irq_request;
	logic [1:0]  engine_request;
	logic [17:0] block_base;

	modport source (output valid, read_data, irq_request, engine_request, block_base,
		input ready);
	modport sink (input valid, read_data, irq_request, engine_request, block_base,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ethernet_port_csr_controller_core.sv =====
// An accepted item goes to the input register, then to the result register, and waits in
// the input register while the result register holds a result that is not yet taken.
// Throughput: one item per cycle while each result is taken; the CSR update for an item completes in the cycle it
// leaves the input register, so the next item sees it at once.
// Reset (arst_n low): CSRs, base and pending command cleared, a port reset pending,
// interrupt line low, both pipeline stages empty.
`default_nettype none

module ethernet_port_csr_controller_core
	import ethpc_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	ethpc_in_if.sink  req,
	ethpc_out_if.source rsp
);

	ethpc_item_t   item_s1;
	logic          valid_s1;
	ethpc_result_t result_n;
	ethpc_result_t result_q;
	logic          out_valid_q;
	logic          advance;

	// an item moves out of the input register when the result register is free or its result is being taken
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.action      <= req.action;
			item_s1.reg_select  <= req.reg_select;
			item_s1.write_data  <= req.write_data;
			item_s1.engine_bits <= req.engine_bits;
		end
	end

	ethpc_csr u_csr (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (result_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= result_n;
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.read_data      = result_q.read_data;
	assign rsp.irq_request    = result_q.irq_request;
	assign rsp.engine_request = result_q.engine_request;
	assign rsp.block_base     = result_q.block_base;

endmodule

`default_nettype wire

// ===== rtl/core/ethpc_csr.sv =====
`default_nettype none

module ethpc_csr
	import ethpc_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire ethpc_item_t   item,
	output ethpc_result_t      result
);

	logic [7:0]  irq_q, irq_n;
	logic        enable_q, enable_n;
	logic [3:0]  cmd_q, cmd_n;
	logic        timeout_q, timeout_n;
	logic [3:0]  state_q, state_n;
	logic [14:0] csr2_q, csr2_n;
	logic [1:0]  csr3_q, csr3_n;
	logic [17:0] base_q, base_n;
	logic        rip_q, rip_n;
	logic        cip_q, cip_n;
	logic        line_q, line_n;

	logic        raise;
	logic [15:0] rbits;
	logic [15:0] rdata;
	logic [1:0]  ereq;
	logic        do_reset;
	logic [7:0]  irq_w;

	always_comb begin
		irq_n     = irq_q;
		enable_n  = enable_q;
		cmd_n     = cmd_q;
		timeout_n = timeout_q;
		state_n   = state_q;
		csr2_n    = csr2_q;
		csr3_n    = csr3_q;
		base_n    = base_q;
		rip_n     = rip_q;
		cip_n     = cip_q;
		line_n    = line_q;
		raise     = 1'b0;
		rbits     = '0;
		rdata     = '0;
		ereq      = EREQ_NONE;
		do_reset  = 1'b0;
		irq_w     = irq_q & ~item.write_data[15:8];

		unique case (ethpc_action_t'(item.action))
			ACT_READ: begin
				unique case (item.reg_select)
					CSR_0: rdata = {irq_q, |irq_q, enable_q, 2'b00, cmd_q};
					CSR_1: rdata = {8'h00, timeout_q, 3'b000, state_q};
					CSR_2: rdata = {csr2_q, 1'b0};
					CSR_3: rdata = {14'h0000, csr3_q};
					default: rdata = '0;
				endcase
			end
			ACT_WRITE: begin
				unique case (item.reg_select)
					CSR_0: begin
						if (item.write_data[BIT_RESET]) begin
							do_reset = 1'b1;
						end else begin
							irq_n = irq_w;
							if (enable_q ^ item.write_data[BIT_ENABLE]) begin
								enable_n = ~enable_q;
							end else begin
								cmd_n = item.write_data[3:0];
								if (item.write_data[3:0] != CMD_NONE)
									cip_n = 1'b1;
							end
							raise = 1'b1;
						end
					end
					CSR_2: csr2_n = item.write_data[15:1];
					CSR_3: csr3_n = item.write_data[1:0];
					default: ;
				endcase
			end
			ACT_TICK: begin
				priority if (rip_q) begin
					rip_n     = 1'b0;
					state_n   = ST_READY;
					timeout_n = 1'b0;
					raise     = 1'b1;
					rbits     = IRQ_DONE;
				end else if (cip_q) begin
					cip_n = 1'b0;
					unique case (cmd_q)
						CMD_GET_PCB: begin
							base_n = {csr3_q, csr2_q, 1'b0};
							raise  = 1'b1;
							rbits  = IRQ_DONE;
						end
						CMD_GET_CMD: ereq = EREQ_GET_CMD;
						// enable clears with the reset, so the line holds
						CMD_SELF_TEST: do_reset = 1'b1;
						CMD_RUN: begin
							state_n = ST_RUNNING;
							raise   = 1'b1;
							rbits   = IRQ_DONE;
						end
						CMD_POLL: ereq = EREQ_POLL;
						CMD_HALT: begin
							state_n = ST_READY;
							raise   = 1'b1;
							rbits   = IRQ_DONE;
						end
						default: begin
							raise = 1'b1;
							rbits = IRQ_DONE;
						end
					endcase
				end else begin
					// nothing pending: hold everything
				end
			end
			ACT_ENGINE: begin
				raise = 1'b1;
				rbits = item.engine_bits;
			end
			default: ;
		endcase

		if (do_reset) begin
			irq_n     = '0;
			enable_n  = 1'b0;
			cmd_n     = CMD_NONE;
			timeout_n = 1'b0;
			state_n   = ST_RESET;
			csr2_n    = '0;
			csr3_n    = '0;
			base_n    = '0;
			rip_n     = 1'b1;
			cip_n     = 1'b0;
		end

		if (raise) begin
			timeout_n = rbits[0];
			irq_n     = irq_n | rbits[15:8];
			if (enable_n)
				line_n = |irq_n;
		end
	end

	always_comb begin
		result.read_data      = rdata;
		result.irq_request    = line_n;
		result.engine_request = ereq;
		result.block_base     = (ereq != EREQ_NONE) ? base_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_q     <= '0;
			enable_q  <= 1'b0;
			cmd_q     <= CMD_NONE;
			timeout_q <= 1'b0;
			state_q   <= ST_RESET;
			csr2_q    <= '0;
			csr3_q    <= '0;
			base_q    <= '0;
			rip_q     <= 1'b1;
			cip_q     <= 1'b0;
			line_q    <= 1'b0;
		end else if (en) begin
			irq_q     <= irq_n;
			enable_q  <= enable_n;
			cmd_q     <= cmd_n;
			timeout_q <= timeout_n;
			state_q   <= state_n;
			csr2_q    <= csr2_n;
			csr3_q    <= csr3_n;
			base_q    <= base_n;
			rip_q     <= rip_n;
			cip_q     <= cip_n;
			line_q    <= line_n;
		end
	end

endmodule

`default_nettype wire

// ===== sim/ethernet_port_csr_controller_core_tb.sv =====
`default_nettype none

module ethernet_port_csr_controller_core_tb;
	import ethpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ITEM_TARGET = 1200;
	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned HOLD_AT     = 300;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned DRAIN_WAIT  = 8;

	localparam logic [15:0] IRQ_MASK  = 16'hFF00;
	localparam logic [15:0] CSR2_MASK = 16'hFFFE;

	typedef struct packed {
		logic [15:0] csr0;
		logic [15:0] csr1;
		logic [15:0] csr2;
		logic [1:0]  csr3;
		logic [17:0] base;
		logic        reset_pend;
		logic        cmd_pend;
		logic        line;
	} port_state_t;

	logic clk = 1'b0;
	logic arst_n;

	ethpc_in_if  req_if ();
	ethpc_out_if rsp_if ();

	ethernet_port_csr_controller_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic port_state_t clear_port(input port_state_t s);
		s.reset_pend = 1'b1;
		s.cmd_pend   = 1'b0;
		s.csr0       = '0;
		s.csr1       = {12'd0, ST_RESET};
		s.csr2       = '0;
		s.csr3       = '0;
		s.base       = '0;
		return s;
	endfunction

	function automatic port_state_t merge_irq(input port_state_t s, input logic [15:0] bits);
		s.csr1[7] = bits[0];
		s.csr0    = s.csr0 | (bits & IRQ_MASK);
		s.csr0[7] = |s.csr0[15:8];
		// line only follows the summary while enabled
		if (s.csr0[BIT_ENABLE]) begin
			s.line = s.csr0[7];
		end
		return s;
	endfunction

	function automatic port_state_t port_step(input port_state_t s, input ethpc_item_t it,
			output ethpc_result_t r);
		r = '0;
		case (it.action)
			ACT_READ: begin
				case (it.reg_select)
					CSR_0:   r.read_data = s.csr0;
					CSR_1:   r.read_data = s.csr1;
					CSR_2:   r.read_data = s.csr2;
					default: r.read_data = {14'd0, s.csr3};
				endcase
			end
			ACT_WRITE: begin
				case (it.reg_select)
					CSR_0: begin
						s.csr0 = s.csr0 & ~(it.write_data & IRQ_MASK);
						if (it.write_data[BIT_RESET]) begin
							s = clear_port(s);
						end else begin
							if (s.csr0[BIT_ENABLE] != it.write_data[BIT_ENABLE]) begin
								s.csr0[BIT_ENABLE] = ~s.csr0[BIT_ENABLE];
							end else begin
								s.csr0[3:0] = it.write_data[3:0];
								if (it.write_data[3:0] != CMD_NONE) begin
									s.cmd_pend = 1'b1;
								end
							end
							s = merge_irq(s, 16'd0);
						end
					end
					CSR_2:   s.csr2 = it.write_data & CSR2_MASK;
					CSR_3:   s.csr3 = it.write_data[1:0];
					default: ;
				endcase
			end
			ACT_TICK: begin
				if (s.reset_pend) begin
					s.reset_pend = 1'b0;
					s.csr1       = {12'd0, ST_READY};
					s = merge_irq(s, IRQ_DONE);
				end else if (s.cmd_pend) begin
					s.cmd_pend = 1'b0;
					case (s.csr0[3:0])
						CMD_GET_PCB: begin
							s.base = {s.csr3, s.csr2};
							s = merge_irq(s, IRQ_DONE);
						end
						CMD_GET_CMD: r.engine_request = EREQ_GET_CMD;
						CMD_SELF_TEST: begin
							s = clear_port(s);
							s = merge_irq(s, 16'd0);
						end
						CMD_RUN: begin
							s.csr1[3:0] = ST_RUNNING;
							s = merge_irq(s, IRQ_DONE);
						end
						CMD_POLL: r.engine_request = EREQ_POLL;
						CMD_HALT: begin
							s.csr1[3:0] = ST_READY;
							s = merge_irq(s, IRQ_DONE);
						end
						default: s = merge_irq(s, IRQ_DONE);
					endcase
				end
			end
			default: s = merge_irq(s, it.engine_bits);
		endcase
		r.irq_request = s.line;
		if (r.engine_request != EREQ_NONE) begin
			r.block_base = s.base;
		end
		return s;
	endfunction

	function automatic ethpc_item_t mk(input logic [1:0] act, input logic [1:0] sel,
			input logic [15:0] wd, input logic [15:0] eb);
		ethpc_item_t it;
		it.action      = act;
		it.reg_select  = sel;
		it.write_data  = wd;
		it.engine_bits = eb;
		return it;
	endfunction

	function automatic int unsigned draw_wait(input bit fast);
		return fast ? 0 : $urandom_range(0, 9);
	endfunction

	// stimulus planning
	port_state_t plan_model = clear_port('0);
	ethpc_item_t pending_items[$];
	int unsigned n_planned = 0;

	task automatic add(input ethpc_item_t it);
		ethpc_result_t unused;
		pending_items.push_back(it);
		plan_model = port_step(plan_model, it, unused);
		n_planned++;
	endtask

	task automatic add_reads(input int unsigned max_n);
		int unsigned n;
		n = $urandom_range(0, max_n);
		repeat (n) add(mk(ACT_READ, 2'($urandom), 16'($urandom), 16'($urandom)));
	endtask

	function automatic logic [3:0] pick_command();
		logic [3:0] any_cmd;
		any_cmd = 4'($urandom);
		case ($urandom_range(0, 6))
			0:       return CMD_GET_PCB;
			1:       return CMD_GET_CMD;
			2:       return CMD_SELF_TEST;
			3:       return CMD_RUN;
			4:       return CMD_POLL;
			5:       return CMD_HALT;
			default: return any_cmd;
		endcase
	endfunction

	// command write that keeps the enable, then the tick that runs it
	task automatic issue_command(input logic [3:0] cmd);
		logic [15:0] wd;
		if (cmd == CMD_GET_PCB && $urandom_range(0, 1) == 0) begin
			add(mk(ACT_WRITE, CSR_2, 16'($urandom), 16'($urandom)));
			add(mk(ACT_WRITE, CSR_3, 16'($urandom), 16'($urandom)));
		end
		wd             = 16'($urandom);
		wd[BIT_ENABLE] = plan_model.csr0[BIT_ENABLE];
		wd[BIT_RESET]  = 1'b0;
		wd[3:0]        = cmd;
		add(mk(ACT_WRITE, CSR_0, wd, 16'($urandom)));
		add_reads(2);
		add(mk(ACT_TICK, 2'($urandom), 16'($urandom), 16'($urandom)));
		if (cmd == CMD_GET_CMD || cmd == CMD_POLL) begin
			add_reads(2);
			add(mk(ACT_ENGINE, 2'($urandom), 16'($urandom), 16'($urandom)));
		end
	endtask

	// driver state
	ethpc_item_t cur_item = '0;
	bit          offering = 1'b0;
	bit          in_taken = 1'b0;
	bit          in_fast  = 1'b0;
	int unsigned in_gap   = 0;

	// receiver state
	bit          out_taken = 1'b0;
	bit          out_fast  = 1'b0;
	bit          hold_done = 1'b0;
	int unsigned out_wait  = 0;
	int unsigned hold_left = 0;

	// checking state
	port_state_t   port_model = clear_port('0);
	ethpc_result_t expected_results[$];
	ethpc_item_t   seen_item;
	ethpc_result_t predicted;
	ethpc_result_t want;
	ethpc_result_t got;
	int unsigned   n_in        = 0;
	int unsigned   n_out       = 0;
	int unsigned   n_act[4]    = '{0, 0, 0, 0};
	int unsigned   n_requests  = 0;
	int unsigned   n_irq_high  = 0;
	int unsigned   errors      = 0;
	int unsigned   idle_cycles = 0;

	task automatic check_field(input string name, input logic [17:0] exp_v,
			input logic [17:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else begin
			if (in_taken) begin
				in_taken = 1'b0;
				offering = 1'b0;
				in_gap   = draw_wait(in_fast);
				if ($urandom_range(0, 49) == 0) begin
					in_fast = ~in_fast;
				end
			end
			if (!offering) begin
				if (in_gap != 0) begin
					in_gap--;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					offering = 1'b1;
				end
			end
			req_if.valid       <= offering;
			req_if.action      <= cur_item.action;
			req_if.reg_select  <= cur_item.reg_select;
			req_if.write_data  <= cur_item.write_data;
			req_if.engine_bits <= cur_item.engine_bits;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (out_taken) begin
				out_taken = 1'b0;
				out_wait  = draw_wait(out_fast);
				if ($urandom_range(0, 49) == 0) begin
					out_fast = ~out_fast;
				end
			end
			// hold off once for a long stretch so the block backs up
			if (!hold_done && n_in >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (out_wait != 0) begin
				out_wait--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				seen_item = mk(req_if.action, req_if.reg_select, req_if.write_data,
					req_if.engine_bits);
				port_model = port_step(port_model, seen_item, predicted);
				expected_results.push_back(predicted);
				in_taken = 1'b1;
				n_in++;
				n_act[seen_item.action]++;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				out_taken = 1'b1;
				n_out++;
				got.read_data      = rsp_if.read_data;
				got.irq_request    = rsp_if.irq_request;
				got.engine_request = rsp_if.engine_request;
				got.block_base     = rsp_if.block_base;
				if (got.engine_request != EREQ_NONE) begin
					n_requests++;
				end
				if (got.irq_request) begin
					n_irq_high++;
				end
				if (expected_results.size() == 0) begin
					$error("result item arrived with no item pending");
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("read_data", 18'(want.read_data), 18'(got.read_data));
					check_field("irq_request", 18'(want.irq_request),
						18'(got.irq_request));
					check_field("engine_request", 18'(want.engine_request),
						18'(got.engine_request));
					check_field("block_base", want.block_base, got.block_base);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [15:0] wd;
		int unsigned pick;

		arst_n              = 1'b0;
		req_if.valid        = 1'b0;
		req_if.action       = ACT_READ;
		req_if.reg_select   = CSR_0;
		req_if.write_data   = '0;
		req_if.engine_bits  = '0;
		rsp_if.ready        = 1'b0;

		// directed: finish reset, register masks, each command, the odd cases
		add(mk(ACT_TICK, CSR_0, 16'h0000, 16'h0000));
		add(mk(ACT_WRITE, CSR_1, 16'hFFFF, 16'h0000));
		add(mk(ACT_WRITE, CSR_2, 16'hFFFF, 16'h0000));
		add(mk(ACT_WRITE, CSR_3, 16'hFFFF, 16'h0000));
		add(mk(ACT_READ, CSR_1, 16'h0000, 16'h0000));
		add(mk(ACT_READ, CSR_3, 16'h0000, 16'h0000));
		add(mk(ACT_WRITE, CSR_0, {9'd0, 1'b1, 6'd0}, 16'h0000));
		add(mk(ACT_WRITE, CSR_0, {IRQ_MASK[15:8], 4'h4, CMD_GET_PCB}, 16'h0000));
		add(mk(ACT_TICK, CSR_0, 16'h0000, 16'h0000));
		add(mk(ACT_WRITE, CSR_0, {IRQ_DONE[15:8], 4'h4, CMD_GET_CMD}, 16'h0000));
		add(mk(ACT_TICK, CSR_0, 16'h0000, 16'h0000));
		add(mk(ACT_ENGINE, CSR_0, 16'h0000, 16'hFFFF));
		add(mk(ACT_READ, CSR_0, 16'hFFFF, 16'hFFFF));
		add(mk(ACT_WRITE, CSR_0, {IRQ_MASK[15:8], 4'h4, CMD_POLL}, 16'h0000));
		add(mk(ACT_TICK, CSR_0, 16'h0000, 16'h0000));
		add(mk(ACT_ENGINE, CSR_0, 16'h0000, 16'h0001));
		add(mk(ACT_WRITE, CSR_0, {8'h00, 4'h4, CMD_RUN}, 16'h0000));
		add(mk(ACT_TICK, CSR_0, 16'h0000, 16'h0000));
		add(mk(ACT_WRITE, CSR_0, {8'h00, 4'h4, CMD_HALT}, 16'h0000));
		add(mk(ACT_TICK, CSR_0, 16'h0000, 16'h0000));
		add(mk(ACT_WRITE, CSR_0, {8'h00, 4'h4, 4'd5}, 16'h0000));
		add(mk(ACT_TICK, CSR_0, 16'h0000, 16'h0000));
		add(mk(ACT_WRITE, CSR_0, {8'h00, 4'h4, CMD_NONE}, 16'h0000));
		add(mk(ACT_TICK, CSR_0, 16'h0000, 16'h0000));
		add(mk(ACT_WRITE, CSR_0, {8'h00, 4'h4, CMD_SELF_TEST}, 16'h0000));
		add(mk(ACT_TICK, CSR_0, 16'h0000, 16'h0000));
		add(mk(ACT_WRITE, CSR_0, 16'hFFFF, 16'hFFFF));

		// random: mostly command sequences, the rest toggles, resets and noise
		while (n_planned < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				issue_command(pick_command());
			end else if (pick < 70) begin
				wd             = 16'($urandom);
				wd[BIT_RESET]  = 1'b0;
				wd[BIT_ENABLE] = ~plan_model.csr0[BIT_ENABLE];
				add(mk(ACT_WRITE, CSR_0, wd, 16'($urandom)));
			end else if (pick < 75) begin
				wd            = 16'($urandom);
				wd[BIT_RESET] = 1'b1;
				add(mk(ACT_WRITE, CSR_0, wd, 16'($urandom)));
				add_reads(2);
				add(mk(ACT_TICK, 2'($urandom), 16'($urandom), 16'($urandom)));
			end else if (pick < 80) begin
				add(mk(ACT_ENGINE, 2'($urandom), 16'($urandom), 16'($urandom)));
			end else begin
				add(mk(2'($urandom), 2'($urandom), 16'($urandom), 16'($urandom)));
			end
		end

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		while (n_in < n_planned) @(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("ran %0d items: %0d reads, %0d writes, %0d ticks, %0d engine completions",
			n_in, n_act[ACT_READ], n_act[ACT_WRITE], n_act[ACT_TICK], n_act[ACT_ENGINE]);
		$display("checked %0d results: %0d engine requests, %0d with irq high, %0d errors",
			n_out, n_requests, n_irq_high, errors);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
